### hdl/msct_pkg.sv
// package for the mongolian script transliterator
// holds the word types, the queue entry type and the letter table; no dependencies
package msct_pkg;

  // input word: one code point
  typedef struct packed {
    logic [20:0] code_point;
    logic        string_start;
  } in_word_t;

  // result word: one output byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_word_t;

  // bytes of one item, oldest in slot 0, cnt of them valid (1..5)
  typedef struct packed {
    logic [4:0][7:0] bytes;
    logic [2:0]      cnt;
  } entry_t;

  // queue status between the queue and its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // one table entry: zero, one or two latin characters
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
  } latin_t;

  localparam logic [20:0] MONG_FIRST = 21'h01810;
  localparam logic [20:0] MONG_LAST  = 21'h01842;
  localparam logic [20:0] CP_NNBSP   = 21'h0202F;
  localparam logic [20:0] CP_MVS     = 21'h0180E;
  localparam logic [20:0] CP_SPACE   = 21'h00020;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h0D800;
  localparam logic [20:0] SURR_LAST  = 21'h0DFFF;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_DASH    = 8'h2D;

  function automatic latin_t mk(input logic [1:0] len, input logic [7:0] b0,
                                input logic [7:0] b1);
    latin_t r;
    r.len = len;
    r.b0  = b0;
    r.b1  = b1;
    return r;
  endfunction

  // latin spelling of U+1810 + idx
  function automatic latin_t latin_of(input logic [5:0] idx);
    latin_t r;
    unique case (idx)
      6'd0:    r = mk(2'd1, "0", 8'h00);
      6'd1:    r = mk(2'd1, "1", 8'h00);
      6'd2:    r = mk(2'd1, "2", 8'h00);
      6'd3:    r = mk(2'd1, "3", 8'h00);
      6'd4:    r = mk(2'd1, "4", 8'h00);
      6'd5:    r = mk(2'd1, "5", 8'h00);
      6'd6:    r = mk(2'd1, "6", 8'h00);
      6'd7:    r = mk(2'd1, "7", 8'h00);
      6'd8:    r = mk(2'd1, "8", 8'h00);
      6'd9:    r = mk(2'd1, "9", 8'h00);
      6'd16:   r = mk(2'd1, "a", 8'h00);
      6'd17:   r = mk(2'd1, "e", 8'h00);
      6'd18:   r = mk(2'd1, "i", 8'h00);
      6'd19:   r = mk(2'd1, "0", 8'h00);
      6'd20:   r = mk(2'd1, "u", 8'h00);
      6'd21:   r = mk(2'd1, "o", 8'h00);
      6'd22:   r = mk(2'd1, "v", 8'h00);
      6'd23:   r = mk(2'd1, "e", 8'h00);
      6'd24:   r = mk(2'd1, "n", 8'h00);
      6'd25:   r = mk(2'd2, "n", "g");
      6'd26:   r = mk(2'd1, "b", 8'h00);
      6'd27:   r = mk(2'd1, "p", 8'h00);
      6'd28:   r = mk(2'd1, "h", 8'h00);
      6'd29:   r = mk(2'd1, "g", 8'h00);
      6'd30:   r = mk(2'd1, "m", 8'h00);
      6'd31:   r = mk(2'd1, "l", 8'h00);
      6'd32:   r = mk(2'd1, "s", 8'h00);
      6'd33:   r = mk(2'd2, "s", "h");
      6'd34:   r = mk(2'd1, "t", 8'h00);
      6'd35:   r = mk(2'd1, "d", 8'h00);
      6'd36:   r = mk(2'd2, "c", "h");
      6'd37:   r = mk(2'd1, "j", 8'h00);
      6'd38:   r = mk(2'd1, "y", 8'h00);
      6'd39:   r = mk(2'd1, "r", 8'h00);
      6'd40:   r = mk(2'd1, "w", 8'h00);
      6'd41:   r = mk(2'd1, "f", 8'h00);
      6'd42:   r = mk(2'd1, "k", 8'h00);
      6'd43:   r = mk(2'd2, "k", "h");
      6'd44:   r = mk(2'd2, "t", "s");
      6'd45:   r = mk(2'd2, "d", "z");
      6'd46:   r = mk(2'd1, "h", 8'h00);
      6'd47:   r = mk(2'd1, "z", 8'h00);
      6'd48:   r = mk(2'd2, "l", "h");
      6'd49:   r = mk(2'd2, "z", "h");
      6'd50:   r = mk(2'd2, "c", "h");
      default: r = mk(2'd0, 8'h00, 8'h00);
    endcase
    return r;
  endfunction

endpackage

### hdl/mongolian_script_transliterator_unit.sv
// an accepted item is registered first in the queue and then in the output stage
// throughput: one result byte per cycle while pop is held; an item yields 0 to 5 bytes,
//   handed out one at a time by the output stage; items yielding no byte skip the queue
// a two-entry queue lets the front take new items while the back still hands out bytes
// reset: synchronous, clears the separator flag, the byte count, the queue and the output
module mongolian_script_transliterator_unit #(
  parameter int OUTPUT_BYTES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  msct_pkg::in_word_t  item,
  output logic                empty,
  input  logic                pop,
  output msct_pkg::out_word_t result
);

  logic                accept;
  logic                q_push;
  logic                q_pop;
  msct_pkg::entry_t    q_wdata;
  msct_pkg::entry_t    q_rdata;
  msct_pkg::q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !full;

  // classify and build byte lists
  msct_front #(
    .OUTPUT_BYTES(OUTPUT_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // decoupling queue
  msct_fifo #(
    .DEPTH(2)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wdata  (q_wdata),
    .rd     (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // serialize bytes
  msct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### hdl/msct_front.sv
// front end: accepts code points, classifies them, builds the byte list
// of each item and applies the output byte limit; uses msct_pkg
module msct_front #(
  parameter int OUTPUT_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  msct_pkg::in_word_t item,
  output logic              q_push,
  output msct_pkg::entry_t  q_data
);

  localparam int CW = (OUTPUT_BYTES > 2) ? $clog2(OUTPUT_BYTES) : 1;
  localparam int WW = (CW > 3) ? CW : 3;
  localparam logic [CW-1:0] LIMIT = CW'(OUTPUT_BYTES - 1);

  logic          pending_dash;
  logic [CW-1:0] bytes_emitted;

  logic [20:0]     cp;
  logic [20:0]     off;
  logic            pend_eff;
  logic [CW-1:0]   be_eff;
  logic            is_space;
  logic            is_sep;
  logic            is_bad;
  logic            dash;
  logic            pending_next;
  msct_pkg::latin_t lat;
  logic [3:0][7:0] body;
  logic [2:0]      blen;
  logic [4:0][7:0] list;
  logic [2:0]      n;
  logic [CW-1:0]   rem;
  logic [WW-1:0]   rem_w;
  logic [WW-1:0]   n_w;
  logic [WW-1:0]   k_w;

  // classify the code point
  always_comb begin
    cp       = item.code_point;
    off      = cp - msct_pkg::MONG_FIRST;
    pend_eff = item.string_start ? 1'b0 : pending_dash;
    be_eff   = item.string_start ? '0 : bytes_emitted;
    is_space = (cp == msct_pkg::CP_SPACE);
    is_sep   = (cp == msct_pkg::CP_NNBSP) || (cp == msct_pkg::CP_MVS);
    is_bad   = (cp == '0) || (cp > msct_pkg::CP_MAX) ||
               ((cp >= msct_pkg::SURR_FIRST) && (cp <= msct_pkg::SURR_LAST));
    lat      = msct_pkg::latin_of(off[5:0]);
    if (!((cp >= msct_pkg::MONG_FIRST) && (cp <= msct_pkg::MONG_LAST))) begin
      lat.len = 2'd0;
    end
  end

  // body bytes: space, table letters or utf-8; separators and invalid code points give none
  always_comb begin
    body = '0;
    blen = 3'd0;
    if (is_space) begin
      body[0] = msct_pkg::CH_SPACE;
      blen    = 3'd1;
    end else if (is_sep) begin
      blen = 3'd0;
    end else if (lat.len != 2'd0) begin
      body[0] = lat.b0;
      body[1] = lat.b1;
      blen    = {1'b0, lat.len};
    end else if (is_bad) begin
      blen = 3'd0;
    end else if (cp < 21'h80) begin
      body[0] = cp[7:0];
      blen    = 3'd1;
    end else if (cp < 21'h800) begin
      body[0] = {3'b110, cp[10:6]};
      body[1] = {2'b10, cp[5:0]};
      blen    = 3'd2;
    end else if (cp < 21'h10000) begin
      body[0] = {4'b1110, cp[15:12]};
      body[1] = {2'b10, cp[11:6]};
      body[2] = {2'b10, cp[5:0]};
      blen    = 3'd3;
    end else begin
      body[0] = {5'b11110, cp[20:18]};
      body[1] = {2'b10, cp[17:12]};
      body[2] = {2'b10, cp[11:6]};
      body[3] = {2'b10, cp[5:0]};
      blen    = 3'd4;
    end
  end

  // dash in front, then cut at the byte limit
  always_comb begin
    dash         = pend_eff && !is_space;
    pending_next = is_sep;
    if (dash) begin
      list = {body, msct_pkg::CH_DASH};
      n    = blen + 3'd1;
    end else begin
      list = {8'h00, body};
      n    = blen;
    end
    rem   = LIMIT - be_eff;
    rem_w = WW'(rem);
    n_w   = WW'(n);
    k_w   = (n_w < rem_w) ? n_w : rem_w;
    q_data.bytes = list;
    q_data.cnt   = k_w[2:0];
    q_push       = accept && (k_w != '0);
  end

  // separator flag and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_dash  <= 1'b0;
      bytes_emitted <= '0;
    end else if (accept) begin
      pending_dash  <= pending_next;
      bytes_emitted <= be_eff + CW'(k_w);
    end
  end

endmodule

### hdl/msct_fifo.sv
// short queue of byte-list entries between front and back ends
// flop storage, one write and one read per cycle; uses msct_pkg
module msct_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  msct_pkg::entry_t    wdata,
  input  logic                rd,
  output msct_pkg::entry_t    rdata,
  output msct_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  msct_pkg::entry_t store [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign rdata        = store[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

### hdl/msct_back.sv
// back end: takes byte-list entries from the queue and hands out one
// byte per word, marking the last byte of each item; uses msct_pkg
module msct_back (
  input  logic                clk,
  input  logic                rst,
  input  msct_pkg::q_status_t q_status,
  input  msct_pkg::entry_t    q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output msct_pkg::out_word_t result
);

  msct_pkg::entry_t cur;
  logic [2:0]       pos;
  logic             cur_valid;
  logic             last;
  logic             take;

  assign last  = (pos + 3'd1) == cur.cnt;
  assign take  = pop && cur_valid;
  assign q_pop = !q_status.empty && (!cur_valid || (take && last));
  assign empty = !cur_valid;
  assign result.out_byte = cur.bytes[pos];
  assign result.run_last = last;

  // current entry and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      pos       <= 3'd0;
    end else if (take) begin
      if (last) begin
        cur_valid <= 1'b0;
        pos       <= 3'd0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // a held entry always has bytes and the position stays inside it
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.cnt != 3'd0) && (cur.cnt <= 3'd5))
    else $error("held entry has a bad byte count");

  a_pos_inside: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (pos < cur.cnt))
    else $error("byte position past end of entry");

  // taking a middle byte keeps the same entry and moves one position on
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> cur_valid && (pos == $past(pos) + 3'd1))
    else $error("byte position did not advance");

  // with the queue empty, taking the last byte drains the back end
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && last && q_status.empty) |=> !cur_valid)
    else $error("back end still holds a word after its last byte");

endmodule
